// ----- rtl/fptm_pkg.sv -----
// Shared types, codes and constants for the four-level page table mapper.
// No dependencies; imported by every module under rtl/.
package fptm_pkg;

   localparam int POOL_PAGES_DEF    = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;
   localparam int PAGE_SHIFT        = 12;
   localparam int PA_W              = 52;
   localparam int VA_W              = 48;
   localparam int VPN_W             = VA_W - PAGE_SHIFT;
   localparam int FLAG_W            = 12;
   localparam int PAGES_W           = 7;
   localparam int CSR_IDX_W         = 1;

   localparam logic [PAGES_W-1:0] POOL_PAGES_RESET = 7'd64;

   // entry bits
   localparam logic [PA_W-1:0] PTE_PRESENT     = 52'h1;
   localparam logic [PA_W-1:0] PTE_TABLE_FLAGS = 52'h7;  // present | write | user

   localparam logic REQ_MAP   = 1'b0;
   localparam logic REQ_UNMAP = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_PAGES   = 2'd1;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'b1;

   typedef enum logic {
      UNIT_ADD,
      UNIT_SUB
   } unit_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CHECK,
      ST_ALLOC,
      ST_LEAF,
      ST_RESP
   } walk_state_type;

   // status in the low bits
   typedef struct packed {
      logic [1:0] tables_made;
      logic       invalidate;
      logic [1:0] status;
   } result_type;

endpackage

// ----- rtl/fptm_table_ram.sv -----
// Table store: single write port, single registered read port.
// Depends on fptm_pkg for the entry width.
module fptm_table_ram
   import fptm_pkg::*;
#(
   parameter int DEPTH = POOL_PAGES_DEF * ENTRIES_PER_TABLE,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [PA_W-1:0] wr_data,
   input  logic [AW-1:0]   rd_addr,
   output logic [PA_W-1:0] rd_data
);

   logic [PA_W-1:0] mem [DEPTH];
   logic [PA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fptm_addr_unit.sv -----
// Shared 52-bit add/subtract unit with registered result.
// Depends on fptm_pkg for widths and op codes.
module fptm_addr_unit
   import fptm_pkg::*;
(
   input  logic            clock,
   input  unit_op_type     op,
   input  logic [PA_W-1:0] a,
   input  logic [PA_W-1:0] b,
   output logic [PA_W-1:0] result
);

   logic [PA_W-1:0] result_ff;
   logic [PA_W-1:0] result_in;

   always_comb begin
      case (op)
         UNIT_ADD: result_in = a + b;
         default:  result_in = a - b;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- rtl/fptm_walker.sv -----
// Walk sequencer: clears the store, walks four levels, allocates tables.
// Depends on fptm_pkg; drives fptm_table_ram and fptm_addr_unit ports.
module fptm_walker
   import fptm_pkg::*;
#(
   parameter int POOL_PAGES = POOL_PAGES_DEF,
   parameter int AW         = $clog2(POOL_PAGES) + IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [VA_W-1:0]    req_va,
   input  logic [PA_W-1:0]    req_pa,
   input  logic [FLAG_W-1:0]  req_flags,
   input  logic [PA_W-1:0]    pool_base,
   input  logic [PAGES_W-1:0] pool_pages,
   output logic               res_valid,
   input  logic               res_ready,
   output result_type         res,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [PA_W-1:0]    ram_wdata,
   output logic [AW-1:0]      ram_raddr,
   input  logic [PA_W-1:0]    ram_rdata,
   output unit_op_type        unit_op,
   output logic [PA_W-1:0]    unit_a,
   output logic [PA_W-1:0]    unit_b,
   input  logic [PA_W-1:0]    unit_res
);

   localparam int PW    = $clog2(POOL_PAGES);
   localparam int NPW   = $clog2(POOL_PAGES + 1);
   localparam int CW    = (NPW > PAGES_W) ? NPW : PAGES_W;
   localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
   localparam int OFF_W = PA_W - PAGE_SHIFT;

   walk_state_type   state_ff, state_in;
   logic [1:0]       lvl_ff, lvl_in;
   logic [PW-1:0]    page_ff, page_in;
   logic [NPW-1:0]   next_page_ff, next_page_in;
   logic [1:0]       made_ff, made_in;
   logic [1:0]       status_ff, status_in;
   logic             inval_ff, inval_in;
   logic             kind_ff, kind_in;
   logic [VPN_W-1:0] vpn_ff, vpn_in;
   logic [PA_W-1:0]  leaf_ff, leaf_in;
   logic [AW-1:0]    clear_ff, clear_in;

   logic [IDX_W-1:0] idx;
   logic [AW-1:0]    slot_addr;
   logic [PA_W-1:0]  base_addr;
   logic             pool_full;
   logic             off_bad;

   always_comb begin
      case (lvl_ff)
         2'd0:    idx = vpn_ff[3*IDX_W +: IDX_W];  // va[47:39]
         2'd1:    idx = vpn_ff[2*IDX_W +: IDX_W];  // va[38:30]
         2'd2:    idx = vpn_ff[IDX_W +: IDX_W];    // va[29:21]
         default: idx = vpn_ff[0 +: IDX_W];        // va[20:12]
      endcase
   end

   assign slot_addr = {page_ff, idx};
   assign base_addr = {pool_base[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   assign pool_full = (CW'(next_page_ff) >= CW'(pool_pages))
                   || (next_page_ff >= NPW'(POOL_PAGES));
   assign off_bad   = unit_res[PA_W-1:PAGE_SHIFT] >= OFF_W'(POOL_PAGES);

   assign res = '{tables_made: made_ff, invalidate: inval_ff, status: status_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         next_page_ff <= NPW'(1);
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         next_page_ff <= next_page_in;
      end
      lvl_ff    <= lvl_in;
      page_ff   <= page_in;
      made_ff   <= made_in;
      status_ff <= status_in;
      inval_ff  <= inval_in;
      kind_ff   <= kind_in;
      vpn_ff    <= vpn_in;
      leaf_ff   <= leaf_in;
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      page_in      = page_ff;
      next_page_in = next_page_ff;
      made_in      = made_ff;
      status_in    = status_ff;
      inval_in     = inval_ff;
      kind_in      = kind_ff;
      vpn_in       = vpn_ff;
      leaf_in      = leaf_ff;
      clear_in     = clear_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = slot_addr;
      ram_wdata    = '0;
      ram_raddr    = slot_addr;
      unit_op      = UNIT_SUB;
      unit_a       = {ram_rdata[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      unit_b       = base_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_ff;
            clear_in  = clear_ff + AW'(1);
            if (clear_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_kind;
               vpn_in    = req_va[VA_W-1:PAGE_SHIFT];
               leaf_in   = {req_pa[PA_W-1:PAGE_SHIFT], req_flags};
               lvl_in    = 2'd0;
               page_in   = '0;
               made_in   = 2'd0;
               status_in = STATUS_OK;
               inval_in  = 1'b0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (lvl_ff == 2'd3) begin
               // unmap leaf
               if ((ram_rdata & PTE_PRESENT) != '0) begin
                  ram_we   = 1'b1;
                  inval_in = 1'b1;
               end else begin
                  status_in = STATUS_NOT_MAPPED;
               end
               state_in = ST_RESP;
            end else if ((ram_rdata & PTE_PRESENT) != '0) begin
               state_in = ST_CHECK;
            end else if (kind_ff == REQ_UNMAP) begin
               status_in = STATUS_NOT_MAPPED;
               state_in  = ST_RESP;
            end else if (pool_full) begin
               status_in = STATUS_NO_PAGES;
               state_in  = ST_RESP;
            end else begin
               unit_op  = UNIT_ADD;
               unit_a   = base_addr;
               unit_b   = {{(OFF_W - PW){1'b0}}, next_page_ff[PW-1:0],
                           {PAGE_SHIFT{1'b0}}};
               state_in = ST_ALLOC;
            end
         end
         ST_CHECK: begin
            if (off_bad) begin
               status_in = (kind_ff == REQ_MAP) ? STATUS_NO_PAGES : STATUS_NOT_MAPPED;
               state_in  = ST_RESP;
            end else begin
               page_in  = unit_res[PAGE_SHIFT +: PW];
               lvl_in   = lvl_ff + 2'd1;
               state_in = (lvl_ff == 2'd2 && kind_ff == REQ_MAP) ? ST_LEAF : ST_READ;
            end
         end
         ST_ALLOC: begin
            ram_we       = 1'b1;
            ram_wdata    = unit_res | PTE_TABLE_FLAGS;
            page_in      = next_page_ff[PW-1:0];
            next_page_in = next_page_ff + NPW'(1);
            made_in      = made_ff + 2'd1;
            lvl_in       = lvl_ff + 2'd1;
            state_in     = (lvl_ff == 2'd2) ? ST_LEAF : ST_READ;
         end
         ST_LEAF: begin
            ram_we    = 1'b1;
            ram_wdata = leaf_ff;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/four_level_page_table_mapper.sv -----
// Each table level takes a store read, an entry decode and an add/sub check (or a table
// allocation); a map then writes its leaf, an unmap reads and clears the last-level entry.
// A new word is taken only once the previous result has moved to the output register;
// early failures finish sooner. The walk is bound by the single table-store port and
// the shared 52-bit adder. Reset (synchronous) clears config, allocator and the store
// with a sweep during which req_tready stays low.
module four_level_page_table_mapper
   import fptm_pkg::*;
#(
   parameter int POOL_PAGES = POOL_PAGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [111:0]         req_tdata,  // virt_addr[47:0], phys_addr[99:48], leaf_flags[111:100]
   input  logic                 req_tuser,  // req_type (0 map, 1 unmap)
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,  // status[1:0], invalidate[2], tables_made[4:3], zero
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PA_W-1:0]      csr_wdata
);

   localparam int PW    = $clog2(POOL_PAGES);
   localparam int AW    = PW + IDX_W;
   localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;

   // config registers
   logic [PA_W-1:0]    pool_base_ff;
   logic [PAGES_W-1:0] pool_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_pages_ff <= POOL_PAGES_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_POOL_BASE) begin
            pool_base_ff <= csr_wdata;
         end else if (csr_index == CSR_POOL_PAGES) begin
            pool_pages_ff <= csr_wdata[PAGES_W-1:0];
         end
      end
   end

   // walker <-> store / adder
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [PA_W-1:0] ram_wdata;
   logic [AW-1:0]   ram_raddr;
   logic [PA_W-1:0] ram_rdata;
   unit_op_type     unit_op;
   logic [PA_W-1:0] unit_a;
   logic [PA_W-1:0] unit_b;
   logic [PA_W-1:0] unit_res;

   // result hand-off into the output register
   logic       res_valid;
   logic       res_ready;
   result_type res;

   // output register: a finished word may wait here while the next request walks
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   fptm_walker #(
      .POOL_PAGES (POOL_PAGES),
      .AW         (AW)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_va     (req_tdata[47:0]),
      .req_pa     (req_tdata[99:48]),
      .req_flags  (req_tdata[111:100]),
      .pool_base  (pool_base_ff),
      .pool_pages (pool_pages_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .unit_op    (unit_op),
      .unit_a     (unit_a),
      .unit_b     (unit_b),
      .unit_res   (unit_res)
   );

   fptm_table_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   fptm_addr_unit u_adder (
      .clock  (clock),
      .op     (unit_op),
      .a      (unit_a),
      .b      (unit_b),
      .result (unit_res)
   );

`ifndef SYNTH
   // store sweep keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request accepted during store clear");

   // only a successful unmap invalidates, and unmap never allocates
   a_inval_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.invalidate |->
         rsp_data_ff.status == STATUS_OK && rsp_data_ff.tables_made == 2'd0)
      else $error("invalidate with failure status or allocation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_data_ff.status == STATUS_OK
                  || rsp_data_ff.status == STATUS_NO_PAGES
                  || rsp_data_ff.status == STATUS_NOT_MAPPED)
      else $error("undefined status code");
`endif

endmodule
